/* hw/rtl/bold_pkg.sv */
// ----------------------------------------------------------------------------
// bold_pkg
// Shared types and constants of the bounded ordered list deque: command and
// status codes, field widths, store geometry and sequencer states.
// ----------------------------------------------------------------------------
package bold_pkg;

   // store geometry
   localparam int CAPACITY   = 256;
   localparam int DATA_WIDTH = 32;
   localparam int SLOT_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // word field widths, fixed by the channel format
   localparam int COMMAND_W = 3;
   localparam int VALUE_W   = 32;
   localparam int POS_W     = 9;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 9;

   // width that holds both a count and a position, plus one guard bit
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_INSERT     = 3'd4,
      CMD_REMOVE     = 3'd5,
      CMD_REVERSE    = 3'd6,
      CMD_CLEAR      = 3'd7
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_FULL   = 2'd2,
      STAT_BADPOS = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SH_RD,
      ST_SH_WR,
      ST_INS_WR,
      ST_RM_RD,
      ST_RM_CAP,
      ST_SH2_RD,
      ST_SH2_WR,
      ST_DONE
   } state_type;

endpackage

/* hw/rtl/bold_req_if.sv */
// ----------------------------------------------------------------------------
// bold_req_if
// Command channel: one word carries a command, a value and a position.
// ----------------------------------------------------------------------------
interface bold_req_if;
   import bold_pkg::*;

   logic                 valid;
   logic                 ready;
   command_type          command;
   logic [VALUE_W-1:0]   value;
   logic [POS_W-1:0]     position;

   modport source (output valid, output command, output value, output position,
                   input ready);
   modport sink   (input valid, input command, input value, input position,
                   output ready);
endinterface

/* hw/rtl/bold_rsp_if.sv */
// ----------------------------------------------------------------------------
// bold_rsp_if
// Result channel: one word per command with value, status, count and flag.
// ----------------------------------------------------------------------------
interface bold_rsp_if;
   import bold_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [VALUE_W-1:0]   value_out;
   status_type           status;
   logic [COUNT_W-1:0]   count;
   logic                 empty_flag;

   modport source (output valid, output value_out, output status, output count,
                   output empty_flag, input ready);
   modport sink   (input valid, input value_out, input status, input count,
                   input empty_flag, output ready);
endinterface

/* hw/rtl/bounded_ordered_list_deque_top.sv */
// ----------------------------------------------------------------------------
// bounded_ordered_list_deque_top
// Ordered sequence of up to CAPACITY values in a circular store with one read
// and one write port, driven by a small sequencer around one shared slot adder.
// ----------------------------------------------------------------------------
//
//   channel    direction  contents
//   req_chan   in         command, value, position
//   rsp_chan   out        value_out, status, count, empty_flag
//
// reverse, clear and rejected commands pass from decode straight to the result
// step; push at an end first writes the new element, and pop at an end first
// reads and captures the taken element. insert at a middle position first
// shifts each element towards the back with one read and one write, and remove
// at a middle position shifts each element forward in the same manner.
// reset clears count, front slot and order flag at once; the store is not
// cleared and is only ever read at live slots.
// a new word is taken while a result still waits in the output register; the
// sequencer only holds in its final step while that register is occupied.
// ----------------------------------------------------------------------------
module bounded_ordered_list_deque_top (
   input  logic        clock,
   input  logic        reset,
   bold_req_if.sink    req_chan,
   bold_rsp_if.source  rsp_chan
);
   import bold_pkg::*;

   // element store
   logic [DATA_WIDTH-1:0] mem [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  rd_en;
   logic [SLOT_W-1:0]     rd_addr;
   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;

   // sequencer state
   state_type             state_ff, state_in;
   status_type            status_ff, status_in;
   logic [CNT_W-1:0]      rank_ff, rank_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [DATA_WIDTH-1:0] got_ff, got_in;
   logic [SLOT_W-1:0]     front_ff, front_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  flip_ff, flip_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   // shared slot unit
   logic [CNT_W-1:0]      unit_rank;
   logic [CNT_W:0]        unit_sum;
   logic [SLOT_W-1:0]     unit_slot;

   // command decode
   logic [CMP_W-1:0]      c_w;
   logic [CMP_W-1:0]      pos_w;
   logic [CMP_W-1:0]      p_ins;
   logic [CMP_W-1:0]      p_rm;
   logic [CMP_W-1:0]      r_ins;
   logic [CMP_W-1:0]      r_rm;
   logic                  rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // rank fed to the slot unit in each step
   always_comb begin
      case (state_ff)
         ST_IDLE:   unit_rank = CNT_W'(CAPACITY - 1);
         ST_SH_RD:  unit_rank = idx_ff - CNT_W'(1);
         ST_SH_WR:  unit_rank = idx_ff;
         ST_INS_WR: unit_rank = rank_ff;
         ST_RM_RD:  unit_rank = rank_ff;
         ST_RM_CAP: unit_rank = CNT_W'(1);
         ST_SH2_RD: unit_rank = idx_ff + CNT_W'(1);
         ST_SH2_WR: unit_rank = idx_ff;
         default:   unit_rank = '0;
      endcase
   end

   // slot = (front + rank) mod capacity, one add and one compare
   assign unit_sum  = (CNT_W+1)'(front_ff) + (CNT_W+1)'(unit_rank);
   assign unit_slot = (unit_sum >= (CNT_W+1)'(CAPACITY))
                      ? SLOT_W'(unit_sum - (CNT_W+1)'(CAPACITY))
                      : SLOT_W'(unit_sum);

   // logical to physical position
   assign c_w   = CMP_W'(count_ff);
   assign pos_w = CMP_W'(req_chan.position);

   always_comb begin
      case (req_chan.command)
         CMD_PUSH_FRONT: p_ins = '0;
         CMD_PUSH_BACK:  p_ins = c_w;
         default:        p_ins = pos_w;
      endcase
      case (req_chan.command)
         CMD_POP_FRONT:  p_rm = '0;
         CMD_POP_BACK:   p_rm = c_w - CMP_W'(1);
         default:        p_rm = pos_w;
      endcase
      r_ins = flip_ff ? (c_w - p_ins) : p_ins;
      r_rm  = flip_ff ? (c_w - CMP_W'(1) - p_rm) : p_rm;
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         flip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         flip_ff      <= flip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      rank_ff       <= rank_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      got_ff        <= got_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // store ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // sequencer: next state and outputs
   always_comb begin
      state_in      = state_ff;
      status_in     = status_ff;
      rank_in       = rank_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      got_in        = got_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      flip_in       = flip_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rd_en         = 1'b0;
      rd_addr       = unit_slot;
      wr_en         = 1'b0;
      wr_addr       = unit_slot;
      wr_data       = val_ff;
      req_chan.ready = 1'b0;

      case (state_ff)
         // take a word and decode it
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               val_in    = DATA_WIDTH'(req_chan.value);
               got_in    = '0;
               status_in = STAT_OK;
               state_in  = ST_DONE;
               case (req_chan.command)
                  CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        status_in = STAT_FULL;
                     end else if (p_ins > c_w) begin
                        status_in = STAT_BADPOS;
                     end else begin
                        rank_in = CNT_W'(r_ins);
                        idx_in  = count_ff;
                        if (r_ins == '0) begin
                           front_in = unit_slot;
                           state_in = ST_INS_WR;
                        end else if (c_w > r_ins) begin
                           state_in = ST_SH_RD;
                        end else begin
                           state_in = ST_INS_WR;
                        end
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else if (p_rm >= c_w) begin
                        status_in = STAT_BADPOS;
                     end else begin
                        rank_in  = CNT_W'(r_rm);
                        idx_in   = CNT_W'(r_rm);
                        state_in = ST_RM_RD;
                     end
                  end
                  CMD_REVERSE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        flip_in = !flip_ff;
                     end
                  end
                  default: begin
                     count_in = '0;
                     front_in = '0;
                     flip_in  = 1'b0;
                  end
               endcase
            end
         end

         // move one element towards the back: read the one before
         ST_SH_RD: begin
            rd_en    = 1'b1;
            state_in = ST_SH_WR;
         end

         ST_SH_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
            idx_in  = idx_ff - CNT_W'(1);
            if ((idx_ff - CNT_W'(1)) > rank_ff) begin
               state_in = ST_SH_RD;
            end else begin
               state_in = ST_INS_WR;
            end
         end

         // place the new element
         ST_INS_WR: begin
            wr_en    = 1'b1;
            wr_data  = val_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = ST_DONE;
         end

         // fetch the element being taken out
         ST_RM_RD: begin
            rd_en    = 1'b1;
            state_in = ST_RM_CAP;
         end

         ST_RM_CAP: begin
            got_in = rd_data_ff;
            if (rank_ff == '0) begin
               front_in = unit_slot;
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end else if (CNT_W'(rank_ff + CNT_W'(1)) < count_ff) begin
               state_in = ST_SH2_RD;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end
         end

         // move one element towards the front: read the one after
         ST_SH2_RD: begin
            rd_en    = 1'b1;
            state_in = ST_SH2_WR;
         end

         ST_SH2_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
            idx_in  = idx_ff + CNT_W'(1);
            if (CNT_W'(idx_ff + CNT_W'(2)) < count_ff) begin
               state_in = ST_SH2_RD;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end
         end

         // load the result word once the output register is free
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = VALUE_W'(got_ff);
               rsp_status_in = status_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_empty_in  = (count_ff == '0);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result channel
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.value_out  = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.count      = rsp_count_ff;
   assign rsp_chan.empty_flag = rsp_empty_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start the sequencer");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         ((count_ff == CNT_W'($past(count_ff) + CNT_W'(1))) ||
          (count_ff == CNT_W'($past(count_ff) - CNT_W'(1))) ||
          (count_ff == '0)))
      else $error("count moved by more than one element");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(state_ff == ST_DONE))
      else $error("result word loaded outside the final step");

   a_empty_status_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STAT_EMPTY)) |-> rsp_empty_ff)
      else $error("empty status with elements still held");

endmodule
